/* src/ip6rt_pkg.sv */
// ----------------------------------------------------------------------------
// ip6rt_pkg
// Shared types, constants and the prefix match helper for the IPv6 route table.
// ----------------------------------------------------------------------------
package ip6rt_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [7:0] MAX_PREFIX = 8'd128;
  localparam logic [7:0] HALF_PREFIX = 8'd64;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_HIT   = 3'd3,
    ST_MISS  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SHIFT  = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [15:0] ns;
    logic [63:0] pfx_hi;
    logic [63:0] pfx_lo;
    logic [7:0]  len;
    logic [63:0] gw_hi;
    logic [63:0] gw_lo;
    logic [7:0]  oif;
  } entry_t;

  // Transaction traveling down the chain. For a lookup, ent.ns and ent.pfx
  // hold the key; on a hit, ent.len/gw/oif take the matched route.
  typedef struct packed {
    cmd_e    cmd;
    phase_e  phase;
    status_e status;
    logic    ent_vld;
    entry_t  ent;
  } tok_t;

  // True when len is at most 128 and the first len bits of the prefix and the address agree.
  function automatic logic prefix_hits(logic [63:0] phi, logic [63:0] plo,
                                       logic [63:0] ahi, logic [63:0] alo,
                                       logic [7:0] len);
    logic [63:0] mhi;
    logic [63:0] mlo;
    logic [7:0]  len_lo;
    len_lo = len - HALF_PREFIX;
    mhi = ~({64{1'b1}} >> len);
    mlo = (len > HALF_PREFIX) ? ~({64{1'b1}} >> len_lo) : 64'd0;
    return (len <= MAX_PREFIX) && (((phi ^ ahi) & mhi) == 64'd0) &&
           (((plo ^ alo) & mlo) == 64'd0);
  endfunction

endpackage

/* src/ip6rt_cell.sv */
// ----------------------------------------------------------------------------
// ip6rt_cell
// One route slot. Compares the passing transaction against its slot, swaps
// entries to make room on an add, and hands the transaction to the next cell.
// ----------------------------------------------------------------------------
module ip6rt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_vld_i,
  input  ip6rt_pkg::tok_t   tok_i,
  output logic              tok_vld_o,
  output ip6rt_pkg::tok_t   tok_o
);

  logic              slot_vld_q, slot_vld_d;
  ip6rt_pkg::entry_t slot_q, slot_d;
  logic              tok_vld_q;
  ip6rt_pkg::tok_t   tok_q, tok_d;

  logic ns_eq, hit, dup, ins_here;

  assign ns_eq = slot_vld_q && (slot_q.ns == tok_i.ent.ns);
  assign hit   = ns_eq && ip6rt_pkg::prefix_hits(slot_q.pfx_hi, slot_q.pfx_lo,
                                                 tok_i.ent.pfx_hi, tok_i.ent.pfx_lo,
                                                 slot_q.len);
  assign dup   = ns_eq && (slot_q.len == tok_i.ent.len) &&
                 (slot_q.pfx_hi == tok_i.ent.pfx_hi) &&
                 (slot_q.pfx_lo == tok_i.ent.pfx_lo);
  assign ins_here = (tok_i.status != ip6rt_pkg::ST_FULL) &&
                    (!slot_vld_q || (slot_q.len < tok_i.ent.len));

  always_comb begin
    tok_d      = tok_i;
    slot_d     = slot_q;
    slot_vld_d = slot_vld_q;
    if (tok_vld_i) begin
      unique case (tok_i.phase)
        ip6rt_pkg::PH_SEARCH: begin
          if (tok_i.cmd == ip6rt_pkg::CMD_LOOKUP) begin
            if (hit) begin
              tok_d.phase     = ip6rt_pkg::PH_DONE;
              tok_d.status    = ip6rt_pkg::ST_HIT;
              tok_d.ent.len   = slot_q.len;
              tok_d.ent.gw_hi = slot_q.gw_hi;
              tok_d.ent.gw_lo = slot_q.gw_lo;
              tok_d.ent.oif   = slot_q.oif;
            end
          end else if (dup) begin
            tok_d.phase  = ip6rt_pkg::PH_DONE;
            tok_d.status = ip6rt_pkg::ST_DUP;
          end else if (ins_here) begin
            // take the new route, push the old one down the chain
            tok_d.phase   = ip6rt_pkg::PH_SHIFT;
            tok_d.ent     = slot_q;
            tok_d.ent_vld = slot_vld_q;
            slot_d        = tok_i.ent;
            slot_vld_d    = tok_i.ent_vld;
          end
        end
        ip6rt_pkg::PH_SHIFT: begin
          tok_d.ent     = slot_q;
          tok_d.ent_vld = slot_vld_q;
          slot_d        = tok_i.ent;
          slot_vld_d    = tok_i.ent_vld;
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      tok_vld_q  <= 1'b0;
    end else begin
      slot_vld_q <= slot_vld_d;
      tok_vld_q  <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    tok_q  <= tok_d;
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

/* src/ipv6_longest_prefix_route_table_core.sv */
// ----------------------------------------------------------------------------
// ipv6_longest_prefix_route_table_core
// IPv6 route table shared by namespaces, kept sorted by descending prefix
// length in a chain of slot cells.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low. It walks the
// chain of TABLE_ENTRIES slot cells one cell per cycle; each cell checks its
// route and, on an add, swaps entries so the table stays sorted. The result
// shows on done_o for one cycle when it leaves the last cell, and busy_o
// drops in the cycle after that, so no new transaction is taken until the
// last one has left the chain. The receiver cannot stall: sample the result
// while done_o is high. Slot storage needs no clearing after reset.
// ----------------------------------------------------------------------------
module ipv6_longest_prefix_route_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [15:0] ns_id_i,
  input  logic [63:0] addr_hi_i,
  input  logic [63:0] addr_lo_i,
  input  logic [7:0]  prefix_len_i,
  input  logic [63:0] gw_hi_i,
  input  logic [63:0] gw_lo_i,
  input  logic [7:0]  out_if_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [7:0]  match_len_o,
  output logic [63:0] route_gw_hi_o,
  output logic [63:0] route_gw_lo_o,
  output logic [7:0]  route_if_o
);

  localparam int unsigned N = ip6rt_pkg::TABLE_ENTRIES;

  logic                       busy_q, busy_d;
  logic [ip6rt_pkg::CNT_W-1:0] count_q, count_d;
  logic                       accept, full;

  logic            chain_vld [N+1];
  ip6rt_pkg::tok_t chain     [N+1];
  ip6rt_pkg::tok_t last;

  assign accept = start_i && !busy_q;
  assign full   = (count_q == ip6rt_pkg::CNT_W'(N));

  always_comb begin
    chain_vld[0]          = accept;
    chain[0].cmd          = ip6rt_pkg::cmd_e'(command_i);
    chain[0].phase        = ip6rt_pkg::PH_SEARCH;
    chain[0].ent_vld      = 1'b1;
    chain[0].ent.ns       = ns_id_i;
    chain[0].ent.pfx_hi   = addr_hi_i;
    chain[0].ent.pfx_lo   = addr_lo_i;
    chain[0].ent.len      = prefix_len_i;
    chain[0].ent.gw_hi    = gw_hi_i;
    chain[0].ent.gw_lo    = gw_lo_i;
    chain[0].ent.oif      = out_if_i;
    if (command_i == ip6rt_pkg::CMD_LOOKUP) begin
      chain[0].status = ip6rt_pkg::ST_MISS;
    end else if (full) begin
      chain[0].status = ip6rt_pkg::ST_FULL;
    end else begin
      chain[0].status = ip6rt_pkg::ST_ADDED;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    ip6rt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_vld_i (chain_vld[g]),
      .tok_i     (chain[g]),
      .tok_vld_o (chain_vld[g+1]),
      .tok_o     (chain[g+1])
    );
  end

  assign last = chain[N];

  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (chain_vld[N]) begin
      busy_d = 1'b0;
      if (last.status == ip6rt_pkg::ST_ADDED) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
    end
  end

  logic is_hit;
  assign is_hit = (last.status == ip6rt_pkg::ST_HIT);

  assign busy_o        = busy_q;
  assign done_o        = chain_vld[N];
  assign status_o      = last.status;
  assign match_len_o   = is_hit ? last.ent.len   : 8'd0;
  assign route_gw_hi_o = is_hit ? last.ent.gw_hi : 64'd0;
  assign route_gw_lo_o = is_hit ? last.ent.gw_lo : 64'd0;
  assign route_if_o    = is_hit ? last.ent.oif   : 8'd0;

endmodule

/* src/ip6rt_checker.sv */
// ----------------------------------------------------------------------------
// ip6rt_checker
// Port-level checks on the route table core, bound to the top level.
// ----------------------------------------------------------------------------
module ip6rt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [7:0]  match_len_o,
  input logic [63:0] route_gw_hi_o,
  input logic [63:0] route_gw_lo_o,
  input logic [7:0]  route_if_o
);

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o not raised after accept");

  // a result only ends a transaction in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result without a transaction in flight");

  // one result per transaction, never two in a row
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe repeated or busy_o held");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ip6rt_pkg::ST_ADDED || status_o == ip6rt_pkg::ST_DUP ||
                status_o == ip6rt_pkg::ST_FULL || status_o == ip6rt_pkg::ST_HIT ||
                status_o == ip6rt_pkg::ST_MISS))
    else $error("undefined status code");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ip6rt_pkg::ST_HIT) |->
      (match_len_o == 8'd0) && (route_gw_hi_o == 64'd0) &&
      (route_gw_lo_o == 64'd0) && (route_if_o == 8'd0))
    else $error("route fields not cleared on a non-hit result");

endmodule

bind ipv6_longest_prefix_route_table_core ip6rt_checker u_ip6rt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .match_len_o   (match_len_o),
  .route_gw_hi_o (route_gw_hi_o),
  .route_gw_lo_o (route_gw_lo_o),
  .route_if_o    (route_if_o)
);

/* verif/ipv6_longest_prefix_route_table_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6_longest_prefix_route_table_core_tb
// Self-checking bench for the shared-namespace IPv6 route table. A short
// table of directed transactions exercises reset, boundary prefix lengths,
// ties, duplicates and foreign namespaces. A long random run follows: it
// fills the table slowly, then keeps adding into a full table. Each result
// is checked against its fixed reply or a behavioral copy of the table.
// ----------------------------------------------------------------------------
module ipv6_longest_prefix_route_table_core_tb;

  localparam int RAND_ITEMS  = 1500;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    ip6rt_pkg::cmd_e cmd;
    logic [15:0]     ns;
    logic [127:0]    addr;
    logic [7:0]      len;
    logic [127:0]    gw;
    logic [7:0]      oif;
  } route_req_t;

  typedef struct {
    ip6rt_pkg::status_e status;
    logic [7:0]         len;
    logic [127:0]       gw;
    logic [7:0]         oif;
  } route_reply_t;

  typedef struct {
    route_req_t   req;
    bit           fixed;
    route_reply_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        command_i = 1'b0;
  logic [15:0] ns_id_i = '0;
  logic [63:0] addr_hi_i = '0;
  logic [63:0] addr_lo_i = '0;
  logic [7:0]  prefix_len_i = '0;
  logic [63:0] gw_hi_i = '0;
  logic [63:0] gw_lo_i = '0;
  logic [7:0]  out_if_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [7:0]  match_len_o;
  logic [63:0] route_gw_hi_o;
  logic [63:0] route_gw_lo_o;
  logic [7:0]  route_if_o;

  ipv6_longest_prefix_route_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .ns_id_i       (ns_id_i),
    .addr_hi_i     (addr_hi_i),
    .addr_lo_i     (addr_lo_i),
    .prefix_len_i  (prefix_len_i),
    .gw_hi_i       (gw_hi_i),
    .gw_lo_i       (gw_lo_i),
    .out_if_i      (out_if_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .match_len_o   (match_len_o),
    .route_gw_hi_o (route_gw_hi_o),
    .route_gw_lo_o (route_gw_lo_o),
    .route_if_o    (route_if_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow route table: packed at the low slots, sorted by descending length.
  logic [15:0]  rt_ns  [ip6rt_pkg::TABLE_ENTRIES];
  logic [127:0] rt_pfx [ip6rt_pkg::TABLE_ENTRIES];
  logic [7:0]   rt_len [ip6rt_pkg::TABLE_ENTRIES];
  logic [127:0] rt_gw  [ip6rt_pkg::TABLE_ENTRIES];
  logic [7:0]   rt_oif [ip6rt_pkg::TABLE_ENTRIES];
  int unsigned  rt_count = 0;

  route_reply_t replies_due[$];
  dir_row_t     directed[$];
  logic [15:0]  ns_pool[6];
  bit           idle_on = 1'b1;
  int           mismatch_cnt = 0;
  int           n_sent = 0;
  int           n_added = 0;
  int           n_dup = 0;
  int           n_full = 0;
  int           n_hit = 0;
  int           n_miss = 0;

  // Leading len bits set; len of 128 or more gives all ones.
  function automatic logic [127:0] len_mask(logic [7:0] len);
    return ~({128{1'b1}} >> len);
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [15:0] pick_ns();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return ns_pool[$urandom_range(0, 5)];
  endfunction

  function automatic route_req_t mk_add(logic [15:0] ns, logic [127:0] addr,
                                        logic [7:0] len, logic [127:0] gw,
                                        logic [7:0] oif);
    route_req_t r;
    r.cmd  = ip6rt_pkg::CMD_ADD;
    r.ns   = ns;
    r.addr = addr;
    r.len  = len;
    r.gw   = gw;
    r.oif  = oif;
    return r;
  endfunction

  // Unused fields of a lookup carry random noise.
  function automatic route_req_t mk_look(logic [15:0] ns, logic [127:0] addr);
    route_req_t r;
    r.cmd  = ip6rt_pkg::CMD_LOOKUP;
    r.ns   = ns;
    r.addr = addr;
    r.len  = 8'($urandom);
    r.gw   = rand128();
    r.oif  = 8'($urandom);
    return r;
  endfunction

  function automatic route_reply_t mk_reply(ip6rt_pkg::status_e st, logic [7:0] len,
                                            logic [127:0] gw, logic [7:0] oif);
    route_reply_t p;
    p.status = st;
    p.len    = len;
    p.gw     = gw;
    p.oif    = oif;
    return p;
  endfunction

  // Apply one transaction to the shadow table and return its reply.
  function automatic route_reply_t route_table_apply(route_req_t r);
    route_reply_t p;
    int unsigned  pos;
    p = mk_reply(ip6rt_pkg::ST_MISS, '0, '0, '0);
    if (r.cmd == ip6rt_pkg::CMD_LOOKUP) begin
      for (int unsigned i = 0; i < rt_count; i++) begin
        if (rt_ns[i] == r.ns && rt_len[i] <= ip6rt_pkg::MAX_PREFIX &&
            ((rt_pfx[i] ^ r.addr) & len_mask(rt_len[i])) == '0) begin
          return mk_reply(ip6rt_pkg::ST_HIT, rt_len[i], rt_gw[i], rt_oif[i]);
        end
      end
      return p;
    end
    for (int unsigned i = 0; i < rt_count; i++) begin
      if (rt_ns[i] == r.ns && rt_len[i] == r.len && rt_pfx[i] == r.addr) begin
        p.status = ip6rt_pkg::ST_DUP;
        return p;
      end
    end
    if (rt_count >= ip6rt_pkg::TABLE_ENTRIES) begin
      p.status = ip6rt_pkg::ST_FULL;
      return p;
    end
    // Ties go behind the older route.
    pos = 0;
    while (pos < rt_count && rt_len[pos] >= r.len) pos++;
    for (int unsigned i = rt_count; i > pos; i--) begin
      rt_ns[i]  = rt_ns[i-1];
      rt_pfx[i] = rt_pfx[i-1];
      rt_len[i] = rt_len[i-1];
      rt_gw[i]  = rt_gw[i-1];
      rt_oif[i] = rt_oif[i-1];
    end
    rt_ns[pos]  = r.ns;
    rt_pfx[pos] = r.addr;
    rt_len[pos] = r.len;
    rt_gw[pos]  = r.gw;
    rt_oif[pos] = r.oif;
    rt_count++;
    p.status = ip6rt_pkg::ST_ADDED;
    return p;
  endfunction

  task automatic push_row(route_req_t req, bit fixed, route_reply_t want);
    dir_row_t row;
    row.req   = req;
    row.fixed = fixed;
    row.want  = want;
    directed.push_back(row);
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Present one transaction and hold it until the block takes it.
  task automatic send_item(route_req_t req, bit fixed, route_reply_t want);
    route_reply_t pred;
    command_i    <= req.cmd;
    ns_id_i      <= req.ns;
    addr_hi_i    <= req.addr[127:64];
    addr_lo_i    <= req.addr[63:0];
    prefix_len_i <= req.len;
    gw_hi_i      <= req.gw[127:64];
    gw_lo_i      <= req.gw[63:0];
    out_if_i     <= req.oif;
    do begin
      start_i <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
      @(posedge clk_i);
    end while (!(start_i && !busy_o));
    pred = route_table_apply(req);
    replies_due.push_back(fixed ? want : pred);
    n_sent++;
  endtask

  task automatic drain_replies();
    start_i <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    route_reply_t want;
    if (rst_ni && done_o) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", status_o));
      end else begin
        want = replies_due.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (match_len_o !== want.len)
          report_mismatch($sformatf("match_len got %0d want %0d", match_len_o, want.len));
        if (route_gw_hi_o !== want.gw[127:64])
          report_mismatch($sformatf("route_gw_hi got %h want %h",
                                    route_gw_hi_o, want.gw[127:64]));
        if (route_gw_lo_o !== want.gw[63:0])
          report_mismatch($sformatf("route_gw_lo got %h want %h",
                                    route_gw_lo_o, want.gw[63:0]));
        if (route_if_o !== want.oif)
          report_mismatch($sformatf("route_if got %0d want %0d", route_if_o, want.oif));
        case (want.status)
          ip6rt_pkg::ST_ADDED: n_added++;
          ip6rt_pkg::ST_DUP:   n_dup++;
          ip6rt_pkg::ST_FULL:  n_full++;
          ip6rt_pkg::ST_HIT:   n_hit++;
          default:             n_miss++;
        endcase
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || done_o) stall = 0;
      else stall++;
    end
    $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("ipv6_longest_prefix_route_table_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    route_req_t   req;
    route_reply_t none;
    route_reply_t added;
    route_reply_t dupl;
    logic [127:0] pfx;
    logic [127:0] base;
    logic [127:0] m;
    logic [127:0] gw;
    logic [15:0]  ns;
    logic [7:0]   len;
    logic [7:0]   boundary_lens[7];
    int           j;
    int           k;
    int           pick;

    pfx   = 128'h2001_0db8_0000_0000_0000_0000_0000_0000;
    none  = mk_reply(ip6rt_pkg::ST_MISS, '0, '0, '0);
    added = mk_reply(ip6rt_pkg::ST_ADDED, '0, '0, '0);
    dupl  = mk_reply(ip6rt_pkg::ST_DUP, '0, '0, '0);
    boundary_lens = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd127, 8'd128};
    ns_pool = '{16'h0000, 16'hffff, 16'h0001, 16'($urandom), 16'($urandom),
                16'($urandom)};

    push_row(mk_look(16'h0000, '0), 1'b1, none);
    push_row(mk_look(16'hffff, '1), 1'b1, none);
    push_row(mk_add(16'h0000, pfx, 8'd32, 128'hfe80_0000_0000_0000_0000_0000_0000_0001,
                    8'd1), 1'b1, added);
    push_row(mk_add(16'h0000, pfx, 8'd32, 128'h1, 8'd2), 1'b1, dupl);
    // Same length, same covered space: the older route must keep winning.
    push_row(mk_add(16'h0000, 128'h2001_0db8_ffff_0000_0000_0000_0000_0000, 8'd32,
                    128'h2, 8'd3), 1'b1, added);
    push_row(mk_add(16'h0000, 128'h2001_0db8_0000_0001_0000_0000_0000_0000, 8'd64,
                    128'h3, 8'd4), 1'b1, added);
    push_row(mk_add(16'h0000, 128'h2001_0db8_0000_0001_8000_0000_0000_0000, 8'd65,
                    128'h4, 8'd5), 1'b1, added);
    push_row(mk_add(16'h0000, '0, 8'd0, '0, 8'd6), 1'b1, added);
    push_row(mk_add(16'h0000, '1, 8'd128, '1, 8'hff), 1'b1, added);
    push_row(mk_add(16'h0000, '0, 8'd200, 128'h5, 8'd7), 1'b1, added);
    push_row(mk_add(16'h0001, pfx, 8'd32, 128'h6, 8'd8), 1'b1, added);
    push_row(mk_add(16'hffff, '0, 8'd128, 128'h7, 8'd9), 1'b1, added);
    push_row(mk_add(16'h0000, pfx, 8'd48, 128'h8, 8'd10), 1'b1, added);
    push_row(mk_look(16'h0000, 128'h2001_0db8_0000_0001_8000_0000_0000_0001), 1'b0, none);
    push_row(mk_look(16'h0000, 128'h2001_0db8_0000_0001_7fff_ffff_ffff_ffff), 1'b0, none);
    push_row(mk_look(16'h0000, 128'h2001_0db8_0000_0002_0000_0000_0000_0000), 1'b0, none);
    push_row(mk_look(16'h0000, 128'h2001_0db8_1234_0000_0000_0000_0000_0000), 1'b0, none);
    push_row(mk_look(16'h0000, '1), 1'b1,
             mk_reply(ip6rt_pkg::ST_HIT, 8'd128, '1, 8'hff));
    push_row(mk_look(16'h0000, 128'h3000_0000_0000_0000_0000_0000_0000_0000), 1'b0, none);
    // Over-long route sits on address zero but must never match.
    push_row(mk_look(16'h0000, '0), 1'b0, none);
    push_row(mk_look(16'h0001, 128'h2001_0db8_ffff_0000_0000_0000_0000_0001), 1'b0, none);
    push_row(mk_look(16'h0002, pfx), 1'b1, none);
    push_row(mk_look(16'hffff, '0), 1'b0, none);
    push_row(mk_look(16'hffff, 128'h1), 1'b1, none);
    push_row(mk_add(16'hffff, '0, 8'd128, 128'h9, 8'd11), 1'b1, dupl);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i].req, directed[i].fixed, directed[i].want);
    drain_replies();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_on = (n < 600) || (n >= 900);
      if (n == 750) drain_replies();
      pick = $urandom_range(99);
      if (rt_count > 0 &&
          pick < (rt_count < ip6rt_pkg::TABLE_ENTRIES ? 4 : 8)) begin
        j   = $urandom_range(0, rt_count - 1);
        req = mk_add(rt_ns[j], rt_pfx[j], rt_len[j], rand128(), 8'($urandom));
      end else if (pick < (rt_count < ip6rt_pkg::TABLE_ENTRIES ? 12 : 18)) begin
        k = $urandom_range(99);
        if (k < 10) len = boundary_lens[$urandom_range(0, 6)];
        else if (k < 20) len = 8'($urandom_range(129, 255));
        else len = 8'($urandom_range(0, 128));
        base = rand128();
        ns   = pick_ns();
        // Nest new routes under existing ones so longest match is exercised.
        if (rt_count > 0 && $urandom_range(1) == 1) begin
          j    = $urandom_range(0, rt_count - 1);
          m    = len_mask(8'($urandom_range(0, 128)));
          base = (rt_pfx[j] & m) | (base & ~m);
          if ($urandom_range(9) < 7) ns = rt_ns[j];
        end
        gw  = ($urandom_range(99) < 15) ? '0 : rand128();
        req = mk_add(ns, base, len, gw, 8'($urandom));
      end else if (rt_count > 0 && $urandom_range(99) < 65) begin
        j    = $urandom_range(0, rt_count - 1);
        m    = len_mask(rt_len[j]);
        base = (rt_pfx[j] & m) | (rand128() & ~m);
        ns   = ($urandom_range(9) == 0) ? pick_ns() : rt_ns[j];
        req  = mk_look(ns, base);
      end else begin
        req = mk_look(pick_ns(), rand128());
      end
      send_item(req, 1'b0, none);
    end

    start_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (ip6rt_pkg::TABLE_ENTRIES + 8) @(posedge clk_i);

    $display("covered %0d transactions: %0d added, %0d duplicate, %0d table full",
             n_sent, n_added, n_dup, n_full);
    $display("lookups: %0d hit, %0d miss; %0d mismatches", n_hit, n_miss, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("ipv6_longest_prefix_route_table_core_tb passed");
    end else begin
      $display("ipv6_longest_prefix_route_table_core_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/ip6rt_pkg.sv
src/ip6rt_cell.sv
src/ipv6_longest_prefix_route_table_core.sv
src/ip6rt_checker.sv
verif/ipv6_longest_prefix_route_table_core_tb.sv
